// ===== sv/fppt_pkg.sv =====
// ---------------------------------------------------------------------------
// fppt_pkg: shared types and constants
// Widths, mode and register codes, and stage payloads for the fixed-point
// point transform pipeline.
// ---------------------------------------------------------------------------
package fppt_pkg;

  localparam int FRACTION_BITS = 10;
  localparam int X_SUBSAMPLE   = 8;
  localparam int Y_SUBSAMPLE   = 15;

  localparam int IN_W   = 24;
  localparam int COEF_W = 32;
  localparam int OUT_W  = 32;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;
  localparam int MODE_W = 2;

  localparam int PROD_W = IN_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ROW_W  = SUM_W - FRACTION_BITS + 1;
  localparam int D_W    = FRACTION_BITS + 1;
  localparam int REM_W  = D_W + 1;
  localparam int Q_W    = FRACTION_BITS + 1;
  localparam int RC_W   = FRACTION_BITS + 2;
  localparam int DIV_STEPS = (Q_W + 2) / 3;
  localparam int FIN_W  = ROW_W + RC_W;
  localparam int SUB_W  = 7;
  localparam int SAT_W  = FIN_W + SUB_W;

  localparam logic signed [ROW_W-1:0] W_ONE      = ROW_W'(1 << FRACTION_BITS);
  localparam logic signed [SUB_W-1:0] X_SUB      = SUB_W'(X_SUBSAMPLE);
  localparam logic signed [SUB_W-1:0] Y_SUB      = SUB_W'(Y_SUBSAMPLE);
  localparam logic signed [SAT_W-1:0] ROUND_BIAS = SAT_W'((1 << FRACTION_BITS) - 1);
  localparam logic signed [SAT_W-1:0] SAT_MAX    = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN    = ~SAT_MAX;

  // transform modes
  localparam logic [MODE_W-1:0] MODE_IDENTITY    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AFFINE      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PERSPECTIVE = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_XX_XY = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_YX_YY = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_WX_WY = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_XY = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_W  = 3'd5;

  typedef struct packed {
    logic signed [IN_W-1:0] user_x;
    logic signed [IN_W-1:0] user_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dev_x;
    logic signed [OUT_W-1:0] dev_y;
    logic                    w_zero;
  } out_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [COEF_W-1:0] xx;
    logic signed [COEF_W-1:0] xy;
    logic signed [COEF_W-1:0] yx;
    logic signed [COEF_W-1:0] yy;
    logic signed [COEF_W-1:0] wx;
    logic signed [COEF_W-1:0] wy;
    logic signed [COEF_W-1:0] ox;
    logic signed [COEF_W-1:0] oy;
    logic signed [COEF_W-1:0] ow;
  } cfg_t;

  typedef struct packed {
    logic signed [IN_W-1:0]   x;
    logic signed [IN_W-1:0]   y;
    logic signed [PROD_W-1:0] p_xx;
    logic signed [PROD_W-1:0] p_xy;
    logic signed [PROD_W-1:0] p_yx;
    logic signed [PROD_W-1:0] p_yy;
    logic signed [PROD_W-1:0] p_wx;
    logic signed [PROD_W-1:0] p_wy;
  } prod_t;

  typedef struct packed {
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [ROW_W-1:0] rx;
    logic signed [ROW_W-1:0] ry;
    logic                    w_neg;
    logic                    w_zero;
    logic                    w_small;
    logic [D_W-1:0]          d;
  } row_t;

  typedef struct packed {
    row_t             row;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic [Q_W-1:0]   num;
  } div_t;

  typedef struct packed {
    logic signed [IN_W-1:0]  x;
    logic signed [IN_W-1:0]  y;
    logic signed [ROW_W-1:0] rx;
    logic signed [ROW_W-1:0] ry;
    logic signed [FIN_W-1:0] prx;
    logic signed [FIN_W-1:0] pry;
    logic                    w_zero;
  } scl_t;

  // clamp to 32-bit signed
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[OUT_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[OUT_W-1:0];
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/fppt_mul.sv =====
// ---------------------------------------------------------------------------
// fppt_mul: coefficient products
// Forms all six coordinate-by-coefficient products at full width.
// ---------------------------------------------------------------------------
module fppt_mul import fppt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  logic  adv;
  prod_t prod_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // products
  always_comb begin
    prod_next.x    = in_data.user_x;
    prod_next.y    = in_data.user_y;
    prod_next.p_xx = in_data.user_x * cfg.xx;
    prod_next.p_xy = in_data.user_y * cfg.xy;
    prod_next.p_yx = in_data.user_x * cfg.yx;
    prod_next.p_yy = in_data.user_y * cfg.yy;
    prod_next.p_wx = in_data.user_x * cfg.wx;
    prod_next.p_wy = in_data.user_y * cfg.wy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= prod_next;
    end
  end

endmodule

// ===== sv/fppt_row.sv =====
// ---------------------------------------------------------------------------
// fppt_row: row sums
// Adds product pairs (only the diagonal products in scale mode), shifts out
// the fraction and adds the offsets; also classifies w for the reciprocal.
// ---------------------------------------------------------------------------
module fppt_row import fppt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output row_t  out_data
);

  logic                    adv;
  logic signed [SUM_W-1:0] sx, sy, sw;
  logic signed [ROW_W-1:0] w, wabs;
  row_t                    row_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // scale/translate drops the cross terms
  always_comb begin
    if (cfg.mode == MODE_SCALE) begin
      sx = SUM_W'(in_data.p_xx);
      sy = SUM_W'(in_data.p_yy);
    end else begin
      sx = SUM_W'(in_data.p_xx) + SUM_W'(in_data.p_xy);
      sy = SUM_W'(in_data.p_yx) + SUM_W'(in_data.p_yy);
    end
    sw = SUM_W'(in_data.p_wx) + SUM_W'(in_data.p_wy);
    w  = ROW_W'(sw >>> FRACTION_BITS) + ROW_W'(cfg.ow);
    wabs = w[ROW_W-1] ? -w : w;
    row_next.x       = in_data.x;
    row_next.y       = in_data.y;
    row_next.rx      = ROW_W'(sx >>> FRACTION_BITS) + ROW_W'(cfg.ox);
    row_next.ry      = ROW_W'(sy >>> FRACTION_BITS) + ROW_W'(cfg.oy);
    row_next.w_neg   = w[ROW_W-1];
    row_next.w_zero  = (w == '0);
    row_next.w_small = (w >= -W_ONE) && (w <= W_ONE);
    row_next.d       = wabs[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= row_next;
    end
  end

endmodule

// ===== sv/fppt_recip.sv =====
// ---------------------------------------------------------------------------
// fppt_recip: reciprocal divider
// Restoring division of one by |w| in three pipeline stages, with four,
// four and three quotient bits per stage.
// ---------------------------------------------------------------------------
module fppt_recip import fppt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  row_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  localparam int STEPS0 = DIV_STEPS;
  localparam int STEPS1 = DIV_STEPS;
  localparam int STEPS2 = Q_W - 2 * DIV_STEPS;

  // n restoring steps on one item
  function automatic div_t dstep(input div_t a, input int n);
    div_t             r;
    logic [REM_W-1:0] rem2;
    r = a;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k < n) begin
        rem2  = {r.rem[REM_W-2:0], r.num[Q_W-1]};
        r.num = r.num << 1;
        if (rem2 >= REM_W'(r.row.d)) begin
          r.rem = rem2 - REM_W'(r.row.d);
          r.q   = {r.q[Q_W-2:0], 1'b1};
        end else begin
          r.rem = rem2;
          r.q   = {r.q[Q_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  logic v1, v2;
  logic adv0, adv1, adv2;
  div_t seed, s1, s2, n0, n1, n2;

  assign adv2      = !out_valid || out_ready;
  assign adv1      = !v2 || adv2;
  assign adv0      = !v1 || adv1;
  assign in_ready  = adv0;

  always_comb begin
    seed.row = in_data;
    seed.rem = '0;
    seed.q   = '0;
    seed.num = Q_W'(1) << FRACTION_BITS;
    n0 = dstep(seed, STEPS0);
    n1 = dstep(s1, STEPS1);
    n2 = dstep(s2, STEPS2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv0) v1 <= in_valid;
      if (adv1) v2 <= v1;
      if (adv2) out_valid <= v2;
    end
    if (adv0) s1 <= n0;
    if (adv1) s2 <= n1;
    if (adv2) out_data <= n2;
  end

endmodule

// ===== sv/fppt_out.sv =====
// ---------------------------------------------------------------------------
// fppt_out: perspective scale and output
// Applies the signed reciprocal, then the subsample factor, the mode
// select and saturation into the output register.
// ---------------------------------------------------------------------------
module fppt_out import fppt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic                    va, adv_a, adv_b;
  logic signed [RC_W-1:0]  qs, rc;
  scl_t                    a, a_next;
  logic signed [FIN_W-1:0] row_x, row_y;
  logic signed [SAT_W-1:0] tx, ty;
  out_t                    res;

  assign adv_b    = !out_valid || out_ready;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;

  // signed reciprocal and row products
  always_comb begin
    qs = $signed(RC_W'(in_data.q));
    if (!in_data.row.w_small || in_data.row.w_zero) rc = '0;
    else if (in_data.row.w_neg) rc = -qs;
    else rc = qs;
    a_next.x      = in_data.row.x;
    a_next.y      = in_data.row.y;
    a_next.rx     = in_data.row.rx;
    a_next.ry     = in_data.row.ry;
    a_next.prx    = FIN_W'(in_data.row.rx) * FIN_W'(rc);
    a_next.pry    = FIN_W'(in_data.row.ry) * FIN_W'(rc);
    a_next.w_zero = in_data.row.w_zero;
  end

  // subsample scale, mode select, saturate
  always_comb begin
    if (cfg.mode == MODE_PERSPECTIVE) begin
      row_x = a.prx >>> FRACTION_BITS;
      row_y = a.pry >>> FRACTION_BITS;
    end else begin
      row_x = FIN_W'(a.rx);
      row_y = FIN_W'(a.ry);
    end
    res.w_zero = 1'b0;
    unique case (cfg.mode)
      MODE_IDENTITY: begin
        tx = SAT_W'(a.x) * SAT_W'(X_SUB);
        ty = SAT_W'(a.y) * SAT_W'(Y_SUB);
        if (tx < 0) tx = tx + ROUND_BIAS;
        if (ty < 0) ty = ty + ROUND_BIAS;
      end
      MODE_PERSPECTIVE: begin
        tx = SAT_W'(row_x) * SAT_W'(X_SUB);
        ty = SAT_W'(row_y) * SAT_W'(Y_SUB);
        res.w_zero = a.w_zero;
      end
      default: begin
        tx = SAT_W'(row_x) * SAT_W'(X_SUB);
        ty = SAT_W'(row_y) * SAT_W'(Y_SUB);
      end
    endcase
    res.dev_x = sat32(tx >>> FRACTION_BITS);
    res.dev_y = sat32(ty >>> FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid;
      if (adv_b) out_valid <= va;
    end
    if (adv_a) a <= a_next;
    if (adv_b) out_data <= res;
  end

endmodule

// ===== sv/fixed_point_point_transform.sv =====
// Throughput: one item per cycle unless the output stalls, set by the seven-stage
// pipeline (products, row sums, three divider stages, reciprocal multiply,
// scale and saturate). A stall holds each stage in place; empty stages keep filling.
// Reset (synchronous, active high) empties the pipeline and loads the
// identity coefficients, unit w offset and identity mode.
// ---------------------------------------------------------------------------
// fixed_point_point_transform: fixed-point 2D point transform
// Config registers and the pipeline that maps user points to device space.
// ---------------------------------------------------------------------------
module fixed_point_point_transform import fppt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [MODE_W-1:0] mode;
  logic [CFG_W-1:0]  xx_xy, yx_yy, wx_wy, off_xy;
  logic [COEF_W-1:0] off_w;
  cfg_t              cfg;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDENTITY;
      xx_xy  <= CFG_W'(1) << FRACTION_BITS;
      yx_yy  <= CFG_W'(1) << (COEF_W + FRACTION_BITS);
      wx_wy  <= '0;
      off_xy <= '0;
      off_w  <= COEF_W'(1) << FRACTION_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode   <= cfg_data[MODE_W-1:0];
        REG_COEF_XX_XY: xx_xy  <= cfg_data;
        REG_COEF_YX_YY: yx_yy  <= cfg_data;
        REG_COEF_WX_WY: wx_wy  <= cfg_data;
        REG_OFFSET_XY:  off_xy <= cfg_data;
        REG_OFFSET_W:   off_w  <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode = mode;
    cfg.xx   = $signed(xx_xy[COEF_W-1:0]);
    cfg.xy   = $signed(xx_xy[CFG_W-1:COEF_W]);
    cfg.yx   = $signed(yx_yy[COEF_W-1:0]);
    cfg.yy   = $signed(yx_yy[CFG_W-1:COEF_W]);
    cfg.wx   = $signed(wx_wy[COEF_W-1:0]);
    cfg.wy   = $signed(wx_wy[CFG_W-1:COEF_W]);
    cfg.ox   = $signed(off_xy[COEF_W-1:0]);
    cfg.oy   = $signed(off_xy[CFG_W-1:COEF_W]);
    cfg.ow   = $signed(off_w);
  end

  logic  p_valid, p_ready, r_valid, r_ready, d_valid, d_ready;
  prod_t p_data;
  row_t  r_data;
  div_t  d_data;

  fppt_mul u_mul (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(p_valid), .out_ready(p_ready), .out_data(p_data)
  );

  fppt_row u_row (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(p_valid), .in_ready(p_ready), .in_data(p_data),
    .out_valid(r_valid), .out_ready(r_ready), .out_data(r_data)
  );

  fppt_recip u_recip (
    .clk(clk), .rst(rst),
    .in_valid(r_valid), .in_ready(r_ready), .in_data(r_data),
    .out_valid(d_valid), .out_ready(d_ready), .out_data(d_data)
  );

  fppt_out u_out (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(d_valid), .in_ready(d_ready), .in_data(d_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== sv/fppt_checker.sv =====
// ---------------------------------------------------------------------------
// fppt_checker: port checks
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
module fppt_checker import fppt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item shown right after reset");

  // a waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item changed or dropped");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  // zero w forces a zero point
  a_wzero_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.w_zero |-> out_data.dev_x == 0 && out_data.dev_y == 0)
    else $error("w_zero set with a nonzero point");

  // an empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

endmodule

bind fixed_point_point_transform fppt_checker u_fppt_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
